[hw/rtl/pedal_plausibility_monitor_unit_assert.svh]
// Assertion macros for the pedal monitor checker.
`ifndef PEDAL_PLAUSIBILITY_MONITOR_UNIT_ASSERT_SVH
`define PEDAL_PLAUSIBILITY_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PPM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pedal monitor check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PPM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pedal monitor check failed");

`endif

[hw/rtl/ppm_pkg.sv]
// Shared types and constants of the pedal plausibility monitor.
package ppm_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int ADC_BITS   = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int VAL_W      = 16;
    localparam int LEVEL_FRAC = 12;
    localparam int NUM_W      = SAMPLE_W + 1;
    localparam int DEN_W      = SAMPLE_W + 2;

    localparam logic [ADC_BITS-1:0] CODE_MAX = '1;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LATCH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_LATCH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_REST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AGREE_LIMIT = 3'd7;

    // sensor slots in processing order
    localparam logic [1:0] SEL_ACCEL_A = 2'd0;
    localparam logic [1:0] SEL_ACCEL_B = 2'd1;
    localparam logic [1:0] SEL_FRONT   = 2'd2;
    localparam logic [1:0] SEL_REAR    = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   accel_min;
        logic [CFG_DATA_W-1:0] accel_max;
        logic [SAMPLE_W-1:0]   brake_min;
        logic [CFG_DATA_W-1:0] brake_max;
        logic [CFG_DATA_W-1:0] accel_latch;
        logic [CFG_DATA_W-1:0] brake_latch;
        logic [CFG_DATA_W-1:0] accel_rest;
        logic [CFG_DATA_W-1:0] agree_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       div_start;
        logic       store;
        logic       mul;
        logic       finish;
        logic [1:0] sel;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/ppm_cfg_regs.sv]
// Calibration and threshold registers of the pedal monitor.
module ppm_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ppm_pkg::cfg_t                       cfg
);

    ppm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_min   <= 12'd1241;
            cfg_reg.accel_max   <= 13'd2482;
            cfg_reg.brake_min   <= 12'd0;
            cfg_reg.brake_max   <= 13'd4096;
            cfg_reg.accel_latch <= 13'd1638;
            cfg_reg.brake_latch <= 13'd410;
            cfg_reg.accel_rest  <= 13'd1229;
            cfg_reg.agree_limit <= 13'd819;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                ppm_pkg::REG_ACCEL_MIN:
                    cfg_reg.accel_min <= cfg_data[ppm_pkg::SAMPLE_W-1:0];
                ppm_pkg::REG_ACCEL_MAX:   cfg_reg.accel_max   <= cfg_data;
                ppm_pkg::REG_BRAKE_MIN:
                    cfg_reg.brake_min <= cfg_data[ppm_pkg::SAMPLE_W-1:0];
                ppm_pkg::REG_BRAKE_MAX:   cfg_reg.brake_max   <= cfg_data;
                ppm_pkg::REG_ACCEL_LATCH: cfg_reg.accel_latch <= cfg_data;
                ppm_pkg::REG_BRAKE_LATCH: cfg_reg.brake_latch <= cfg_data;
                ppm_pkg::REG_ACCEL_REST:  cfg_reg.accel_rest  <= cfg_data;
                ppm_pkg::REG_AGREE_LIMIT: cfg_reg.agree_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/ppm_divider.sv]
// Radix-4 restoring divider that normalizes one sample to saturated Q.FRAC_BITS.
module ppm_divider #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [ppm_pkg::NUM_W-1:0]      num,
    input  logic signed [ppm_pkg::DEN_W-1:0]      den,
    output logic                                  done,
    output logic signed [ppm_pkg::VAL_W-1:0]      quot
);

    localparam int MAG_W = ppm_pkg::SAMPLE_W;
    localparam int DVS_W = ppm_pkg::DEN_W - 1;
    localparam int RMW   = DVS_W + 1;
    localparam int ITER  = (MAG_W + FRAC_BITS + 1) / 2;
    localparam int DW    = 2 * ITER;
    localparam int CNT_W = $clog2(ITER + 1);

    logic [RMW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg, neg_reg, nz_reg, zden_reg;

    logic [ppm_pkg::NUM_W-1:0] num_abs;
    logic [ppm_pkg::DEN_W-1:0] den_abs;

    assign num_abs = num[ppm_pkg::NUM_W-1] ? -num : num;
    assign den_abs = den[ppm_pkg::DEN_W-1] ? -den : den;

    // two restoring steps per cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            rem_next = {rem_next[RMW-2:0], quo_next[DW-1]};
            quo_next = {quo_next[DW-2:0], 1'b0};
            if (rem_next >= {1'b0, dvs_reg})
            begin
                rem_next    = rem_next - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (den != '0);
            done_reg <= (den == '0);
            cnt_reg  <= CNT_W'(ITER);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= DW'(num_abs[MAG_W-1:0]) << FRAC_BITS;
            dvs_reg  <= den_abs[DVS_W-1:0];
            neg_reg  <= num[ppm_pkg::NUM_W-1] ^ den[ppm_pkg::DEN_W-1];
            nz_reg   <= (num != '0);
            zden_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // apply sign and saturate
    always_comb
    begin
        if (zden_reg)
        begin
            if (!nz_reg)
                quot = '0;
            else
                quot = neg_reg ? ppm_pkg::VAL_MIN : ppm_pkg::VAL_MAX;
        end
        else if (!neg_reg)
            quot = (quo_reg > DW'(32767)) ? ppm_pkg::VAL_MAX
                                          : quo_reg[ppm_pkg::VAL_W-1:0];
        else
            quot = (quo_reg >= DW'(32768)) ? ppm_pkg::VAL_MIN
                                           : -quo_reg[ppm_pkg::VAL_W-1:0];
    end

    assign done = done_reg;

endmodule

[hw/rtl/ppm_datapath.sv]
// Sample capture, normalization, plausibility checks and result register.
module ppm_datapath #(
    parameter int FRAC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ppm_pkg::cfg_t                     cfg,
    input  ppm_pkg::cmd_t                     cmd,
    output ppm_pkg::status_t                  status,
    input  logic [ppm_pkg::SAMPLE_W-1:0]      accel_a_sample,
    input  logic [ppm_pkg::SAMPLE_W-1:0]      accel_b_sample,
    input  logic [ppm_pkg::SAMPLE_W-1:0]      front_brake_sample,
    input  logic [ppm_pkg::SAMPLE_W-1:0]      rear_brake_sample,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [ppm_pkg::ADC_BITS-1:0]      throttle_code,
    output logic                              throttle_enable,
    output logic                              overlap_fault,
    output logic                              agreement_fault,
    output logic                              range_fault
);

    localparam int VW  = ppm_pkg::VAL_W;
    localparam int LW  = (FRAC_BITS + 14 > VW + ppm_pkg::LEVEL_FRAC) ?
                         FRAC_BITS + 14 : VW + ppm_pkg::LEVEL_FRAC;
    localparam int RW  = (FRAC_BITS + 5 > VW + 4) ? FRAC_BITS + 5 : VW + 4;
    localparam int CW  = VW + ppm_pkg::ADC_BITS;
    localparam int PW  = ppm_pkg::CFG_DATA_W + VW;

    localparam logic signed [RW-1:0] RNG_ONE = RW'(1) << FRAC_BITS;
    localparam logic signed [RW-1:0] RNG_HI  = RW'(11) << FRAC_BITS;

    logic [ppm_pkg::SAMPLE_W-1:0] samp_reg [4];
    logic signed [VW-1:0]         v_reg    [4];
    logic                         range_reg;

    logic [VW-1:0] d_reg;
    logic [PW-1:0] prod_reg;
    logic          eq_reg, szero_reg, spos_reg;

    logic                         out_valid_reg, latch_reg;
    logic [ppm_pkg::ADC_BITS-1:0] code_reg;
    logic                         en_reg, agree_out_reg, range_out_reg;

    logic [ppm_pkg::SAMPLE_W-1:0]          samp_sel, lo_sel;
    logic [ppm_pkg::CFG_DATA_W-1:0]        hi_sel;
    logic signed [ppm_pkg::NUM_W-1:0]      div_num;
    logic signed [ppm_pkg::DEN_W-1:0]      div_den;
    logic                                  div_done;
    logic signed [VW-1:0]                  div_quot;
    logic signed [RW-1:0]                  rng_v, rng_v10;
    logic                                  quot_oor;

    logic signed [VW:0]   sum_ab, diff_ab;
    logic signed [LW-1:0] a_sc, f_sc, lvl_al, lvl_bl, lvl_ar;
    logic [CW-1:0]        code_wide;
    logic                 agree_f, latch_next, en_next;
    logic [ppm_pkg::ADC_BITS-1:0] code_next;

    // pick the sample and calibration pair for the divider
    always_comb
    begin
        samp_sel = samp_reg[cmd.sel];
        if (cmd.sel[1])
        begin
            lo_sel = cfg.brake_min;
            hi_sel = cfg.brake_max;
        end
        else
        begin
            lo_sel = cfg.accel_min;
            hi_sel = cfg.accel_max;
        end
        div_num = {1'b0, samp_sel} - {1'b0, lo_sel};
        div_den = {1'b0, hi_sel} - {2'b00, lo_sel};
    end

    ppm_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // range check on each value as it comes out of the divider
    always_comb
    begin
        rng_v    = RW'(div_quot);
        rng_v10  = (rng_v <<< 3) + (rng_v <<< 1);
        quot_oor = (rng_v10 < -RNG_ONE) || (rng_v10 > RNG_HI);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            samp_reg[ppm_pkg::SEL_ACCEL_A] <= accel_a_sample;
            samp_reg[ppm_pkg::SEL_ACCEL_B] <= accel_b_sample;
            samp_reg[ppm_pkg::SEL_FRONT]   <= front_brake_sample;
            samp_reg[ppm_pkg::SEL_REAR]    <= rear_brake_sample;
        end
        if (cmd.store)
            v_reg[cmd.sel] <= div_quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            range_reg <= 1'b0;
        else if (cmd.capture)
            range_reg <= 1'b0;
        else if (cmd.store && quot_oor)
            range_reg <= 1'b1;
    end

    // agreement: sum, difference and the limit product
    always_comb
    begin
        sum_ab = (VW+1)'(v_reg[ppm_pkg::SEL_ACCEL_A]) + (VW+1)'(v_reg[ppm_pkg::SEL_ACCEL_B]);
        if (v_reg[ppm_pkg::SEL_ACCEL_A] > v_reg[ppm_pkg::SEL_ACCEL_B])
            diff_ab = (VW+1)'(v_reg[ppm_pkg::SEL_ACCEL_A])
                    - (VW+1)'(v_reg[ppm_pkg::SEL_ACCEL_B]);
        else
            diff_ab = (VW+1)'(v_reg[ppm_pkg::SEL_ACCEL_B])
                    - (VW+1)'(v_reg[ppm_pkg::SEL_ACCEL_A]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg  <= PW'(cfg.agree_limit) * PW'(sum_ab[VW-1:0]);
            d_reg     <= diff_ab[VW-1:0];
            eq_reg    <= (v_reg[ppm_pkg::SEL_ACCEL_A] == v_reg[ppm_pkg::SEL_ACCEL_B]);
            szero_reg <= (sum_ab == '0);
            spos_reg  <= (sum_ab > 0);
        end
    end

    // final decision: level compares, latch, enable and DAC code
    always_comb
    begin
        agree_f = !eq_reg && (szero_reg || (spos_reg && ({d_reg, 13'b0} >= (PW+1)'(prod_reg))));

        a_sc   = LW'(v_reg[ppm_pkg::SEL_ACCEL_A]) <<< ppm_pkg::LEVEL_FRAC;
        f_sc   = LW'(v_reg[ppm_pkg::SEL_FRONT]) <<< ppm_pkg::LEVEL_FRAC;
        lvl_al = LW'(cfg.accel_latch) << FRAC_BITS;
        lvl_bl = LW'(cfg.brake_latch) << FRAC_BITS;
        lvl_ar = LW'(cfg.accel_rest) << FRAC_BITS;

        if ((a_sc > lvl_al) && (f_sc > lvl_bl))
            latch_next = 1'b1;
        else if (latch_reg && (a_sc < lvl_ar))
            latch_next = 1'b0;
        else
            latch_next = latch_reg;

        en_next   = !(latch_next || agree_f || range_reg);
        code_wide = (CW'($unsigned(v_reg[ppm_pkg::SEL_ACCEL_A])) << ppm_pkg::ADC_BITS)
                    >> FRAC_BITS;
        if (en_next && (v_reg[ppm_pkg::SEL_ACCEL_A] > 0))
            code_next = (code_wide > CW'(ppm_pkg::CODE_MAX)) ? ppm_pkg::CODE_MAX
                                                            : code_wide[ppm_pkg::ADC_BITS-1:0];
        else
            code_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            latch_reg     <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
            latch_reg     <= latch_next;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            code_reg      <= code_next;
            en_reg        <= en_next;
            agree_out_reg <= agree_f;
            range_out_reg <= range_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign throttle_code   = code_reg;
    assign throttle_enable = en_reg;
    assign overlap_fault   = latch_reg;
    assign agreement_fault = agree_out_reg;
    assign range_fault     = range_out_reg;

endmodule

[hw/rtl/ppm_ctrl.sv]
// Sequencer that steps one item through the four divisions and the checks.
module ppm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ppm_pkg::status_t   status,
    output ppm_pkg::cmd_t      cmd
);

    ppm_pkg::state_t state_reg, state_next;
    logic [1:0]      sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppm_pkg::ST_IDLE;
            sel_reg   <= ppm_pkg::SEL_ACCEL_A;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            ppm_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = ppm_pkg::ST_LOAD;
                    sel_next   = ppm_pkg::SEL_ACCEL_A;
                end
            ppm_pkg::ST_LOAD:
                state_next = ppm_pkg::ST_DIV;
            ppm_pkg::ST_DIV:
                if (status.div_done)
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = (sel_reg == ppm_pkg::SEL_REAR) ? ppm_pkg::ST_MUL
                                                                : ppm_pkg::ST_LOAD;
                end
            ppm_pkg::ST_MUL:
                state_next = ppm_pkg::ST_FINAL;
            ppm_pkg::ST_FINAL:
                if (status.out_free)
                    state_next = ppm_pkg::ST_IDLE;
            default:
                state_next = ppm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ppm_pkg::ST_IDLE);
        cmd.capture   = (state_reg == ppm_pkg::ST_IDLE) && in_valid;
        cmd.div_start = (state_reg == ppm_pkg::ST_LOAD);
        cmd.store     = (state_reg == ppm_pkg::ST_DIV) && status.div_done;
        cmd.mul       = (state_reg == ppm_pkg::ST_MUL);
        cmd.finish    = (state_reg == ppm_pkg::ST_FINAL) && status.out_free;
        cmd.sel       = sel_reg;
    end

endmodule

[hw/rtl/pedal_plausibility_monitor_unit.sv]
// Top level of the accelerator pedal / brake plausibility monitor.
//
// Each item brings four raw 12-bit ADC codes (two accelerator sensors, front
// and rear brake). Every code is normalized to a signed Q.FRAC_BITS value,
// (code - min) / (max - min) truncated toward zero and saturated to 16 bits,
// by one shared divider that retires two quotient bits per cycle. The monitor
// then runs the accelerator agreement check, the brake/accelerator overlap
// latch and the -0.1..1.1 range check, and emits one result item: the DAC
// code of the first accelerator sensor (0 when any check faults), the enable
// flag and the three fault flags. One item is processed at a time, and its four
// divisions run one after another; a sample whose calibration has max equal
// to min skips its division and finishes sooner. A finished result sits in
// an output register, so the next item is taken while it waits; the block
// only stalls in its last step if that register is still occupied. The
// overlap latch is cleared by reset. Calibration registers are to be written
// by the user through the plain write port while no item is in flight; the
// block itself does not enforce this.
module pedal_plausibility_monitor_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write_en,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ppm_pkg::SAMPLE_W-1:0]      accel_a_sample,
    input  logic [ppm_pkg::SAMPLE_W-1:0]      accel_b_sample,
    input  logic [ppm_pkg::SAMPLE_W-1:0]      front_brake_sample,
    input  logic [ppm_pkg::SAMPLE_W-1:0]      rear_brake_sample,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ppm_pkg::ADC_BITS-1:0]      throttle_code,
    output logic                              throttle_enable,
    output logic                              overlap_fault,
    output logic                              agreement_fault,
    output logic                              range_fault
);

    ppm_pkg::cfg_t    cfg;
    ppm_pkg::cmd_t    cmd;
    ppm_pkg::status_t status;

    // calibration and thresholds
    ppm_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // sequencer: accept, divide four times, multiply, decide
    ppm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, latch and result register
    ppm_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .status             (status),
        .accel_a_sample     (accel_a_sample),
        .accel_b_sample     (accel_b_sample),
        .front_brake_sample (front_brake_sample),
        .rear_brake_sample  (rear_brake_sample),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .throttle_code      (throttle_code),
        .throttle_enable    (throttle_enable),
        .overlap_fault      (overlap_fault),
        .agreement_fault    (agreement_fault),
        .range_fault        (range_fault)
    );

endmodule

[hw/rtl/ppm_checker.sv]
// Port-level checker for the pedal monitor, bound to the top level.
`include "pedal_plausibility_monitor_unit_assert.svh"

module ppm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [ppm_pkg::ADC_BITS-1:0]      throttle_code,
    input logic                              throttle_enable,
    input logic                              overlap_fault,
    input logic                              agreement_fault,
    input logic                              range_fault
);

    // a disabled throttle always drives the cut value
    `PPM_ASSERT_IMP(a_cut_when_off, out_valid && !throttle_enable, throttle_code == '0)
    // enable only with every fault clear
    `PPM_ASSERT_IMP(a_enable_clean, out_valid && throttle_enable, !overlap_fault && !agreement_fault && !range_fault)
    // one item in flight: ready drops right after an accept
    `PPM_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // a stalled result holds
    `PPM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(throttle_code))

endmodule

bind pedal_plausibility_monitor_unit ppm_checker u_ppm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .throttle_code   (throttle_code),
    .throttle_enable (throttle_enable),
    .overlap_fault   (overlap_fault),
    .agreement_fault (agreement_fault),
    .range_fault     (range_fault)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for pedal_plausibility_monitor_unit: a self-checking scoreboard with drive and receive tasks.
module tb;

    localparam int     FRAC            = 12;     // matches the block's FRAC_BITS default
    localparam int     CLK_HALF        = 6;      // 12 ns period
    localparam longint CYCLE_LIMIT     = 300000;
    localparam int     TAIL_CYCLES     = 120;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     PHASE_ITEMS     = 72;
    localparam int     NUM_PHASES      = 6;

    typedef logic [ppm_pkg::SAMPLE_W-1:0]   sample_t;
    typedef logic [ppm_pkg::CFG_DATA_W-1:0] cal_word_t;
    typedef logic [ppm_pkg::CFG_IDX_W-1:0]  cal_index_t;

    typedef struct packed {
        logic [ppm_pkg::ADC_BITS-1:0] code;
        logic                         enable;
        logic                         overlap;
        logic                         agreement;
        logic                         range;
    } throttle_result_t;

    // Scoreboard: mirrors the calibration registers and the overlap latch,
    // predicts one throttle result per accepted sample set, and checks the
    // results in order of arrival.
    class throttle_scoreboard;
        logic [ppm_pkg::CFG_DATA_W-1:0] cal [8];
        bit                             latch_set;
        throttle_result_t               expected_q [$];
        int                             fail_count;

        function new();
            cal[ppm_pkg::REG_ACCEL_MIN]   = 13'd1241;
            cal[ppm_pkg::REG_ACCEL_MAX]   = 13'd2482;
            cal[ppm_pkg::REG_BRAKE_MIN]   = 13'd0;
            cal[ppm_pkg::REG_BRAKE_MAX]   = 13'd4096;
            cal[ppm_pkg::REG_ACCEL_LATCH] = 13'd1638;
            cal[ppm_pkg::REG_BRAKE_LATCH] = 13'd410;
            cal[ppm_pkg::REG_ACCEL_REST]  = 13'd1229;
            cal[ppm_pkg::REG_AGREE_LIMIT] = 13'd819;
            latch_set  = 1'b0;
            fail_count = 0;
        endfunction

        // The two min registers hold 12 bits only; drop the top bit.
        function void write_cal(logic [ppm_pkg::CFG_IDX_W-1:0] idx,
                                logic [ppm_pkg::CFG_DATA_W-1:0] data);
            if (idx == ppm_pkg::REG_ACCEL_MIN || idx == ppm_pkg::REG_BRAKE_MIN)
                cal[idx] = data & 13'h0FFF;
            else
                cal[idx] = data;
        endfunction

        // Signed fraction (code - lo) / (hi - lo) in Q.FRAC, truncated toward
        // zero and saturated to 16 bits; equal calibration saturates by sign.
        function longint normalize(logic [ppm_pkg::SAMPLE_W-1:0] code, longint lo, longint hi);
            longint num;
            longint den;
            longint q;
            num = longint'(code) - lo;
            den = hi - lo;
            if (den == 0)
                return (num > 0) ? 32767 : ((num < 0) ? -32768 : 0);
            q = (num * (longint'(1) <<< FRAC)) / den;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q;
        endfunction

        // Level comparisons against Q1.12 registers, done exactly.
        function bit above_level(longint v, longint level);
            return v * 4096 > level * (longint'(1) <<< FRAC);
        endfunction

        function bit below_level(longint v, longint level);
            return v * 4096 < level * (longint'(1) <<< FRAC);
        endfunction

        function bit outside_band(longint v);
            longint one;
            one = longint'(1) <<< FRAC;
            return (v * 10 < -one) || (v * 10 > 11 * one);
        endfunction

        function void note_sample_set(logic [ppm_pkg::SAMPLE_W-1:0] aa,
                                      logic [ppm_pkg::SAMPLE_W-1:0] ab,
                                      logic [ppm_pkg::SAMPLE_W-1:0] fb,
                                      logic [ppm_pkg::SAMPLE_W-1:0] rb);
            longint a;
            longint b;
            longint f;
            longint r;
            longint s;
            longint d;
            longint c;
            throttle_result_t res;
            a = normalize(aa, cal[ppm_pkg::REG_ACCEL_MIN], cal[ppm_pkg::REG_ACCEL_MAX]);
            b = normalize(ab, cal[ppm_pkg::REG_ACCEL_MIN], cal[ppm_pkg::REG_ACCEL_MAX]);
            f = normalize(fb, cal[ppm_pkg::REG_BRAKE_MIN], cal[ppm_pkg::REG_BRAKE_MAX]);
            r = normalize(rb, cal[ppm_pkg::REG_BRAKE_MIN], cal[ppm_pkg::REG_BRAKE_MAX]);

            // sensor agreement: equal passes, zero sum faults, negative sum passes
            res.agreement = 1'b0;
            if (a != b)
            begin
                s = a + b;
                d = (a > b) ? a - b : b - a;
                if (s == 0)
                    res.agreement = 1'b1;
                else if (s > 0)
                    res.agreement = (2 * d * 4096) >=
                                    (longint'(cal[ppm_pkg::REG_AGREE_LIMIT]) * s);
            end

            // overlap latch: set on pedal and brake together, clear at rest
            if (above_level(a, cal[ppm_pkg::REG_ACCEL_LATCH]) &&
                above_level(f, cal[ppm_pkg::REG_BRAKE_LATCH]))
                latch_set = 1'b1;
            else if (latch_set && below_level(a, cal[ppm_pkg::REG_ACCEL_REST]))
                latch_set = 1'b0;
            res.overlap = latch_set;

            res.range  = outside_band(a) || outside_band(b) || outside_band(f) ||
                         outside_band(r);
            res.enable = !(res.overlap || res.agreement || res.range);

            res.code = '0;
            if (res.enable && a > 0)
            begin
                c = (a <<< ppm_pkg::ADC_BITS) >>> FRAC;
                if (c > 4095)
                    c = 4095;
                res.code = c[ppm_pkg::ADC_BITS-1:0];
            end
            expected_q.push_back(res);
        endfunction

        function void compare_field(string field, logic [ppm_pkg::ADC_BITS-1:0] want,
                                    logic [ppm_pkg::ADC_BITS-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_throttle_result(logic [ppm_pkg::ADC_BITS-1:0] code, logic enable,
                                            logic overlap, logic agreement, logic range);
            throttle_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result item with nothing expected: throttle_code %0d", code);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("throttle_code", want.code, code);
            compare_field("throttle_enable", want.enable, enable);
            compare_field("overlap_fault", want.overlap, overlap);
            compare_field("agreement_fault", want.agreement, agreement);
            compare_field("range_fault", want.range, range);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // Block inputs start at known values; reset is held from time zero.
    logic                           clk                = 1'b0;
    logic                           rst_n              = 1'b0;
    logic                           cfg_write_en       = 1'b0;
    logic [ppm_pkg::CFG_IDX_W-1:0]  cfg_index          = '0;
    logic [ppm_pkg::CFG_DATA_W-1:0] cfg_data           = '0;
    logic                           in_valid           = 1'b0;
    logic [ppm_pkg::SAMPLE_W-1:0]   accel_a_sample     = '0;
    logic [ppm_pkg::SAMPLE_W-1:0]   accel_b_sample     = '0;
    logic [ppm_pkg::SAMPLE_W-1:0]   front_brake_sample = '0;
    logic [ppm_pkg::SAMPLE_W-1:0]   rear_brake_sample  = '0;
    logic                           out_ready          = 1'b0;
    logic                           in_ready;
    logic                           out_valid;
    logic [ppm_pkg::ADC_BITS-1:0]   throttle_code;
    logic                           throttle_enable;
    logic                           overlap_fault;
    logic                           agreement_fault;
    logic                           range_fault;

    throttle_scoreboard             sb_h = new();

    bit                             idle_on      = 1'b1;  // random idling on both sides
    bit                             hold_off_req = 1'b0;  // ask the receiver for a long hold-off
    int                             hold_left    = 0;
    int                             rx_gap       = 0;
    longint                         cycle_count  = 0;
    int                             pedal_pos    = 0;     // Q0.12 pedal travel of the random walk
    int                             brake_pos    = 0;     // Q0.12 brake pressure
    logic [ppm_pkg::CFG_DATA_W-1:0] plan [8];             // calibration to load next

    pedal_plausibility_monitor_unit DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .accel_a_sample     (accel_a_sample),
        .accel_b_sample     (accel_b_sample),
        .front_brake_sample (front_brake_sample),
        .rear_brake_sample  (rear_brake_sample),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .throttle_code      (throttle_code),
        .throttle_enable    (throttle_enable),
        .overlap_fault      (overlap_fault),
        .agreement_fault    (agreement_fault),
        .range_fault        (range_fault)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("cycle limit reached with %0d results outstanding", sb_h.pending());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Receiver: check each accepted result item, then pick out_ready for the
    // next edge. A long hold-off lets the block fill up and stall its input;
    // short random bursts put gaps on every phase of the block's work.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb_h.check_throttle_result(throttle_code, throttle_enable, overlap_fault,
                                       agreement_fault, range_fault);
        if (hold_off_req)
        begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_gap = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one item, maybe after an idle burst, and hold it until accepted.
    // Valid stays high between back-to-back items.
    task automatic send_samples(input logic [ppm_pkg::SAMPLE_W-1:0] aa,
                                input logic [ppm_pkg::SAMPLE_W-1:0] ab,
                                input logic [ppm_pkg::SAMPLE_W-1:0] fb,
                                input logic [ppm_pkg::SAMPLE_W-1:0] rb);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        accel_a_sample     <= aa;
        accel_b_sample     <= ab;
        front_brake_sample <= fb;
        rear_brake_sample  <= rb;
        do
            @(posedge clk);
        while (!in_ready);
        sb_h.note_sample_set(aa, ab, fb, rb);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb_h.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Load all eight calibration registers from plan, one per cycle.
    task automatic apply_plan();
        for (int i = 0; i < 8; i++)
        begin
            cfg_write_en <= 1'b1;
            cfg_index    <= cal_index_t'(i);
            cfg_data     <= plan[i];
            @(posedge clk);
            sb_h.write_cal(cal_index_t'(i), plan[i]);
        end
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // ADC code that the current calibration maps to a Q0.12 travel.
    function automatic logic [ppm_pkg::SAMPLE_W-1:0] code_at(longint travel, longint lo,
                                                             longint hi);
        longint c;
        c = lo + (travel * (hi - lo)) / 4096;
        if (c < 0)
            c = 0;
        if (c > 4095)
            c = 4095;
        return c[ppm_pkg::SAMPLE_W-1:0];
    endfunction

    // Mostly plausible pedal/brake traffic from a random walk, with
    // disagreeing sensors now and then and some fully random noise.
    task automatic send_random_item();
        longint                        a_lo;
        longint                        a_hi;
        longint                        b_lo;
        longint                        b_hi;
        int                            jit;
        logic [ppm_pkg::SAMPLE_W-1:0]  aa;
        logic [ppm_pkg::SAMPLE_W-1:0]  ab;
        logic [ppm_pkg::SAMPLE_W-1:0]  fb;
        logic [ppm_pkg::SAMPLE_W-1:0]  rb;
        a_lo = sb_h.cal[ppm_pkg::REG_ACCEL_MIN];
        a_hi = sb_h.cal[ppm_pkg::REG_ACCEL_MAX];
        b_lo = sb_h.cal[ppm_pkg::REG_BRAKE_MIN];
        b_hi = sb_h.cal[ppm_pkg::REG_BRAKE_MAX];
        if ($urandom_range(0, 99) < 15)
        begin
            aa = sample_t'($urandom);
            ab = sample_t'($urandom);
            fb = sample_t'($urandom);
            rb = sample_t'($urandom);
        end
        else
        begin
            pedal_pos = pedal_pos + int'($urandom_range(0, 1200)) - 600;
            if (pedal_pos < -500)
                pedal_pos = -500;
            if (pedal_pos > 4700)
                pedal_pos = 4700;
            if ($urandom_range(0, 4) == 0)
                brake_pos = $urandom_range(0, 1) ? int'($urandom_range(1000, 4600))
                                                 : int'($urandom_range(0, 300));
            jit = ($urandom_range(0, 9) == 0) ? 600 : 20;
            aa = code_at(pedal_pos, a_lo, a_hi);
            ab = code_at(pedal_pos + int'($urandom_range(0, 2 * jit)) - jit, a_lo, a_hi);
            fb = code_at(brake_pos, b_lo, b_hi);
            rb = code_at(brake_pos + int'($urandom_range(0, 80)) - 40, b_lo, b_hi);
        end
        send_samples(aa, ab, fb, rb);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items on the reset calibration (accel 1241..2482, brake 0..4096).
        send_samples(12'd0, 12'd0, 12'd0, 12'd0);               // accelerator far below range
        send_samples(12'd4095, 12'd4095, 12'd4095, 12'd4095);   // accelerator far above range
        send_samples(12'd1241, 12'd1241, 12'd0, 12'd0);         // pedal at rest
        send_samples(12'd1861, 12'd1861, 12'd0, 12'd0);         // half travel
        hold_off_req = 1'b1;                                    // stall the receiver now
        send_samples(12'd2482, 12'd2482, 12'd0, 12'd0);         // full travel, code clamps
        send_samples(12'd2612, 12'd2612, 12'd0, 12'd0);         // just above 1.1
        send_samples(12'd1111, 12'd1111, 12'd0, 12'd0);         // just below -0.1
        send_samples(12'd1861, 12'd1500, 12'd0, 12'd0);         // sensors disagree
        send_samples(12'd1341, 12'd1141, 12'd0, 12'd0);         // zero sum, unequal
        send_samples(12'd1200, 12'd1141, 12'd0, 12'd0);         // negative sum passes
        send_samples(12'd2000, 12'd2000, 12'd1000, 12'd0);      // pedal and brake: latch
        send_samples(12'd1700, 12'd1700, 12'd0, 12'd0);         // between rest and latch: hold
        send_samples(12'd1241, 12'd1241, 12'd0, 12'd0);         // below rest: clear
        send_samples(12'd1241, 12'd1241, 12'd4095, 12'd4095);   // hard braking alone
        send_samples(12'd4095, 12'd0, 12'd0, 12'd4095);
        send_samples(12'd0, 12'd4095, 12'd4095, 12'd0);
        drain();

        for (int p = 1; p <= NUM_PHASES; p++)
        begin
            case (p)
                1:  // widest calibration, all levels at zero
                begin
                    plan = '{13'd0, 13'd4096, 13'd0, 13'd4096, 13'd0, 13'd0, 13'd0, 13'd0};
                end
                2:  // reversed accelerator, flat brake, all levels at the top
                begin
                    plan = '{13'd4095, 13'd0, 13'd2048, 13'd2048,
                             13'd4096, 13'd4096, 13'd4096, 13'd4096};
                end
                3:  // flat accelerator, reversed brake
                begin
                    plan[ppm_pkg::REG_ACCEL_MIN]   = 13'd2000;
                    plan[ppm_pkg::REG_ACCEL_MAX]   = 13'd2000;
                    plan[ppm_pkg::REG_BRAKE_MIN]   = 13'd3000;
                    plan[ppm_pkg::REG_BRAKE_MAX]   = 13'd500;
                    plan[ppm_pkg::REG_ACCEL_LATCH] = cal_word_t'($urandom_range(0, 4096));
                    plan[ppm_pkg::REG_BRAKE_LATCH] = cal_word_t'($urandom_range(0, 4096));
                    plan[ppm_pkg::REG_ACCEL_REST]  = cal_word_t'($urandom_range(0, 4096));
                    plan[ppm_pkg::REG_AGREE_LIMIT] = cal_word_t'($urandom_range(0, 4096));
                end
                4:  // plausible random calibration
                begin
                    plan[ppm_pkg::REG_ACCEL_MIN]   = cal_word_t'($urandom_range(0, 2000));
                    plan[ppm_pkg::REG_ACCEL_MAX]   =
                        cal_word_t'($urandom_range(plan[ppm_pkg::REG_ACCEL_MIN] + 300, 4096));
                    plan[ppm_pkg::REG_BRAKE_MIN]   = cal_word_t'($urandom_range(0, 2000));
                    plan[ppm_pkg::REG_BRAKE_MAX]   =
                        cal_word_t'($urandom_range(plan[ppm_pkg::REG_BRAKE_MIN] + 300, 4096));
                    plan[ppm_pkg::REG_ACCEL_LATCH] = cal_word_t'($urandom_range(800, 3500));
                    plan[ppm_pkg::REG_BRAKE_LATCH] = cal_word_t'($urandom_range(100, 2000));
                    plan[ppm_pkg::REG_ACCEL_REST]  =
                        cal_word_t'($urandom_range(0, plan[ppm_pkg::REG_ACCEL_LATCH]));
                    plan[ppm_pkg::REG_AGREE_LIMIT] = cal_word_t'($urandom_range(100, 2000));
                end
                5:  // any 13-bit value, min registers keep only 12 bits
                begin
                    for (int i = 0; i < 8; i++)
                        plan[i] = cal_word_t'($urandom);
                end
                default:  // back to the reset calibration
                begin
                    plan = '{13'd1241, 13'd2482, 13'd0, 13'd4096,
                             13'd1638, 13'd410, 13'd1229, 13'd819};
                end
            endcase
            apply_plan();

            if (p == 2)
            begin
                // flat brake: at, above and below its single code
                send_samples(12'd2000, 12'd2000, 12'd2048, 12'd2048);
                send_samples(12'd2000, 12'd2000, 12'd2049, 12'd2047);
            end
            if (p == 3)
            begin
                // flat accelerator: zero, saturate up, saturate down
                send_samples(12'd2000, 12'd2000, 12'd3000, 12'd3000);
                send_samples(12'd2001, 12'd2001, 12'd0, 12'd4095);
                send_samples(12'd1999, 12'd2001, 12'd4095, 12'd0);
            end

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // stretches with and without idling; none in the last phase
                if (p == NUM_PHASES)
                    idle_on = 1'b0;
                else if (i % 24 == 0)
                    idle_on = ($urandom_range(0, 2) != 0);
                if (p == 4 && i == 30)
                    hold_off_req = 1'b1;
                send_random_item();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb_h.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb_h.pending());
            sb_h.fail_count++;
        end
        if (sb_h.fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
